FILE: hdl/cse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg: shared types and helpers of the C string escape encoder
// Holds the descriptor that travels from the classifier to the emitter,
// and the functions that turn a descriptor and a step into a character.
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] PRINT_LOW  = 8'h20;
	localparam logic [7:0] PRINT_HIGH = 8'h7E;
	localparam logic [7:0] DQUOTE     = 8'h22;
	localparam logic [7:0] SQUOTE     = 8'h27;
	localparam logic [6:0] ESC_CHAR   = 7'h5C;
	localparam logic [6:0] OCT_BASE   = 7'h30;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_PAIR,
		KIND_OCTAL
	} kind_t;

	typedef logic [1:0] step_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} desc_t;

	function automatic kind_t classify(logic [7:0] b);
		kind_t k;
		if (b < PRINT_LOW) begin
			if (b >= 8'h07 && b <= 8'h0D) k = KIND_PAIR;
			else k = KIND_OCTAL;
		end else if (b == DQUOTE || b == SQUOTE) begin
			k = KIND_PAIR;
		end else if (b > PRINT_HIGH) begin
			k = KIND_OCTAL;
		end else begin
			k = KIND_PLAIN;
		end
		return k;
	endfunction

	// Letter that follows the backslash; quotes stand for themselves.
	function automatic logic [6:0] pair_letter(logic [7:0] b);
		logic [6:0] c;
		unique case (b)
			8'h07: c = 7'h61;
			8'h08: c = 7'h62;
			8'h09: c = 7'h74;
			8'h0A: c = 7'h6E;
			8'h0B: c = 7'h76;
			8'h0C: c = 7'h66;
			8'h0D: c = 7'h72;
			default: c = b[6:0];
		endcase
		return c;
	endfunction

	function automatic logic [6:0] run_char(desc_t d, step_t step);
		logic [6:0] c;
		case (step)
			2'd0: c = (d.kind == KIND_PLAIN) ? d.value[6:0] : ESC_CHAR;
			2'd1: c = (d.kind == KIND_PAIR) ? pair_letter(d.value)
				: (OCT_BASE | {5'd0, d.value[7:6]});
			2'd2: c = OCT_BASE | {4'd0, d.value[5:3]};
			default: c = OCT_BASE | {4'd0, d.value[2:0]};
		endcase
		return c;
	endfunction

	function automatic logic run_end(desc_t d, step_t step);
		return (d.kind == KIND_PLAIN && step == 2'd0)
			|| (d.kind == KIND_PAIR && step == 2'd1)
			|| (d.kind == KIND_OCTAL && step == 2'd3);
	endfunction

endpackage

FILE: hdl/cse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_front: input stage and classifier
// Accepts one byte per request and registers it with its escape kind.
// ----------------------------------------------------------------------------
module cse_front
	import cse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       push_valid,
	input  logic       push_ready,
	output desc_t      push_data
);

	logic  valid_s1;
	desc_t desc_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			desc_s1.kind  <= classify(in_byte);
			desc_s1.value <= in_byte;
		end
	end

endmodule

FILE: hdl/cse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_queue: descriptor queue
// Small circular queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module cse_queue
	import cse_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  desc_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output desc_t pop_data,
	output logic  full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign push_ready = !full;
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: hdl/cse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_back: escape sequencer
// Steps through each descriptor and drives one character per cycle into
// the output register whenever that register is empty or being taken.
// ----------------------------------------------------------------------------
module cse_back
	import cse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  desc_t      pop_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic       run_last,
	output logic       active
);

	logic       active_q;
	desc_t      cur_q;
	step_t      step_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       run_last_q;
	logic       slot_free;
	logic       src_valid;
	desc_t      src;
	logic       src_end;

	// A run in progress has priority; otherwise the queue head starts a new one.
	assign slot_free = !out_valid_q || out_ready;
	assign src       = active_q ? cur_q : pop_data;
	assign src_valid = active_q || pop_valid;
	assign src_end   = run_end(src, step_q);
	assign pop_ready = slot_free && !active_q;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = run_last_q;
	assign active    = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= src_valid;
			if (src_valid) begin
				active_q <= !src_end;
				step_q   <= src_end ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && src_valid) begin
			out_char_q <= run_char(src, step_q);
			run_last_q <= src_end;
		end
		if (pop_valid && pop_ready) cur_q <= pop_data;
	end

endmodule

FILE: hdl/c_string_escape_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_string_escape_encoder: C string-literal escaping of a byte stream
// Each input byte leaves as a run of one to four ASCII characters.
// ----------------------------------------------------------------------------
// The block takes one raw byte per request and returns its escaped form one
// character per request, with run_last high on the final character of each
// run. A plain byte yields one output character, a backslash-letter or quote
// escape two, and an octal escape four; the output sequencer moves one
// character per cycle while out_ready allows, so it sets the sustained rate.
// Input bytes are taken every cycle while the descriptor queue (QUEUE_DEPTH
// entries) has room; each passes the front register, queue and output register.
module c_string_escape_encoder
	import cse_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic       run_last
);

	logic  push_valid;
	logic  push_ready;
	desc_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	desc_t pop_data;
	logic  queue_full;
	logic  back_active;

	cse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	cse_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.full      (queue_full)
	);

	cse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char (out_char),
		.run_last (run_last),
		.active   (back_active)
	);

	// A taken character that does not end its run is followed at once.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("escape run stalled inside the block");

	// Input stalls only when the front stage is held by a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (push_valid && queue_full))
		else $error("input stalled without a full queue");

	// A run in progress means the output register holds a non-final character.
	a_active_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		back_active |-> (out_valid && !run_last))
		else $error("sequencer active without a pending run character");

endmodule
